// ----- rtl/versioned_adjacency_store_macros.svh -----
// Assertion macros shared by the versioned adjacency store RTL.
`ifndef VERSIONED_ADJACENCY_STORE_MACROS_SVH
`define VERSIONED_ADJACENCY_STORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define VAS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vas assertion failed");

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define VAS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vas assertion failed");

`endif

// ----- rtl/vas_pkg.sv -----
// Shared constants and codes for the versioned adjacency store.
package vas_pkg;

  localparam int NODE_COUNT_DEF   = 1024;
  localparam int DEGREE_LIMIT_DEF = 32;
  localparam int VERSION_BITS_DEF = 8;
  localparam int ID_BITS_DEF      = 10;

  localparam int KIND_W   = 3;
  localparam int LEN_W    = 8;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 6;
  localparam int TOTAL_W  = 11;
  localparam int MAXDEG_W = 6;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  localparam logic [MAXDEG_W-1:0] MAX_DEGREE_RST = MAXDEG_W'(32);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_READ    = 3'd1,
    KIND_SIZE    = 3'd2,
    KIND_DELETE  = 3'd3,
    KIND_RECOVER = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_DISABLED  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_e;

  typedef enum logic {
    REG_MAX_DEGREE = 1'b0,
    REG_DELETE_EN  = 1'b1
  } cfg_reg_e;

endpackage

// ----- rtl/vas_if.sv -----
// Request and result channel interfaces.
interface vas_in_if #(
  parameter int ID_BITS = vas_pkg::ID_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [vas_pkg::KIND_W-1:0] kind;
  logic [ID_BITS-1:0]         node_id;
  logic [ID_BITS-1:0]         nbr_id;
  logic [vas_pkg::LEN_W-1:0]  list_length;
  logic [vas_pkg::LEN_W-1:0]  element_index;

  modport source (output valid, kind, node_id, nbr_id, list_length, element_index,
                  input ready);
  modport sink   (input valid, kind, node_id, nbr_id, list_length, element_index,
                  output ready);
endinterface

interface vas_out_if #(
  parameter int ID_BITS = vas_pkg::ID_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [vas_pkg::STATUS_W-1:0] status;
  logic [ID_BITS-1:0]           nbr_out;
  logic                         neighbor_valid;
  logic                         last;
  logic [vas_pkg::CNT_W-1:0]    neighbor_count;
  logic [vas_pkg::TOTAL_W-1:0]  node_count;
  logic [vas_pkg::TOTAL_W-1:0]  id_limit;

  modport source (output valid, status, nbr_out, neighbor_valid, last,
                  neighbor_count, node_count, id_limit, input ready);
  modport sink   (input valid, status, nbr_out, neighbor_valid, last,
                  neighbor_count, node_count, id_limit, output ready);
endinterface

// ----- rtl/versioned_adjacency_store.sv -----
// Top level of the versioned adjacency store: config registers, memories, sequencer.
//
//  channel | direction | handshake     | contents
//  in_i    | in        | valid/ready   | kind, node_id, nbr_id, list_length, element_index
//  out_o   | out       | valid/ready   | status, neighbor, valid/last flags, counts
//  apb     | in        | psel/penable  | max_degree at 0x0, delete_enabled at 0x4
//
// Path per transaction, no output stalls: insert reads the node record, then the
// neighbor record when it looks up a neighbor version, then reports; too long or
// skipped inserts report at once; delete and recover, unless disabled, and size read
// the node record; other kinds report at once. A read reads each stored entry and then
// its node's version, bound by the single node-memory read port. After reset a clearing
// pass zeroes every node record; in_i.ready stays low until it ends. A held output
// register stalls a read walk at its next survivor and every transaction at its final result.
module versioned_adjacency_store #(
  parameter int NODE_COUNT   = vas_pkg::NODE_COUNT_DEF,
  parameter int DEGREE_LIMIT = vas_pkg::DEGREE_LIMIT_DEF,
  parameter int VERSION_BITS = vas_pkg::VERSION_BITS_DEF,
  parameter int ID_BITS      = vas_pkg::ID_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  vas_in_if.sink                     in_i,
  vas_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vas_pkg::CFG_AW-1:0] paddr,
  input  logic [vas_pkg::CFG_DW-1:0] pwdata,
  output logic [vas_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import vas_pkg::*;
  `include "versioned_adjacency_store_macros.svh"

  localparam int AW  = $clog2(NODE_COUNT);
  localparam int DW  = $clog2(DEGREE_LIMIT + 1);
  localparam int RW  = 2 + VERSION_BITS + DW;
  localparam int IW  = (DEGREE_LIMIT > 1) ? $clog2(DEGREE_LIMIT) : 1;
  localparam int EAW = AW + IW;
  localparam int EW  = ID_BITS + VERSION_BITS;

  logic [MAXDEG_W-1:0] max_degree_q;
  logic                del_en_q;
  logic                wr_cfg;
  logic                busy;

  logic           nrd_en, nwr_en, erd_en, ewr_en;
  logic [AW-1:0]  nrd_addr, nwr_addr;
  logic [RW-1:0]  nrd_data, nwr_data;
  logic [EAW-1:0] erd_addr, ewr_addr;
  logic [EW-1:0]  erd_data, ewr_data;

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_degree_q <= MAX_DEGREE_RST;
      del_en_q     <= 1'b1;
    end else if (wr_cfg) begin
      unique case (cfg_reg_e'(paddr[2]))
        REG_MAX_DEGREE: max_degree_q <= pwdata[MAXDEG_W-1:0];
        REG_DELETE_EN:  del_en_q     <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_e'(paddr[2]))
      REG_MAX_DEGREE: prdata = CFG_DW'(max_degree_q);
      REG_DELETE_EN:  prdata = CFG_DW'(del_en_q);
    endcase
  end

  vas_node_mem #(
    .NODE_COUNT (NODE_COUNT),
    .RW         (RW)
  ) u_node_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (nrd_en),
    .rd_addr_i (nrd_addr),
    .rd_data_o (nrd_data),
    .wr_en_i   (nwr_en),
    .wr_addr_i (nwr_addr),
    .wr_data_i (nwr_data),
    .busy_o    (busy)
  );

  vas_entry_mem #(
    .AW (EAW),
    .DW (EW)
  ) u_entry_mem (
    .clk_i     (clk_i),
    .rd_en_i   (erd_en),
    .rd_addr_i (erd_addr),
    .rd_data_o (erd_data),
    .wr_en_i   (ewr_en),
    .wr_addr_i (ewr_addr),
    .wr_data_i (ewr_data)
  );

  vas_ctrl #(
    .NODE_COUNT   (NODE_COUNT),
    .DEGREE_LIMIT (DEGREE_LIMIT),
    .VERSION_BITS (VERSION_BITS),
    .ID_BITS      (ID_BITS),
    .AW           (AW),
    .RW           (RW),
    .EAW          (EAW),
    .EW           (EW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .busy_i           (busy),
    .max_degree_i     (max_degree_q),
    .delete_enabled_i (del_en_q),
    .in_i             (in_i),
    .out_o            (out_o),
    .nrd_en_o         (nrd_en),
    .nrd_addr_o       (nrd_addr),
    .nrd_data_i       (nrd_data),
    .nwr_en_o         (nwr_en),
    .nwr_addr_o       (nwr_addr),
    .nwr_data_o       (nwr_data),
    .erd_en_o         (erd_en),
    .erd_addr_o       (erd_addr),
    .erd_data_i       (erd_data),
    .ewr_en_o         (ewr_en),
    .ewr_addr_o       (ewr_addr),
    .ewr_data_o       (ewr_data)
  );

  `VAS_ASSERT_IMP(a_clear_blocks_input, busy, !in_i.ready)
  `VAS_ASSERT_NXT(a_one_item_at_a_time, in_i.valid && in_i.ready, !in_i.ready)
  `VAS_ASSERT_IMP(a_neighbor_ok_status, out_o.valid && out_o.neighbor_valid,
                  out_o.status == ST_OK)
endmodule

// ----- rtl/vas_node_mem.sv -----
// Per-node record memory with a clearing pass after reset.
module vas_node_mem #(
  parameter int NODE_COUNT = vas_pkg::NODE_COUNT_DEF,
  parameter int RW         = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_addr_i,
  output logic [RW-1:0]                 rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(NODE_COUNT)-1:0] wr_addr_i,
  input  logic [RW-1:0]                 wr_data_i,
  output logic                          busy_o
);
  import vas_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

  logic [RW-1:0] mem [NODE_COUNT];
  logic [AW-1:0] clr_q;
  logic          busy_q;
  logic [RW-1:0] rd_q;

  logic          we;
  logic [AW-1:0] wa;
  logic [RW-1:0] wd;

  assign we = busy_q | wr_en_i;
  assign wa = busy_q ? clr_q : wr_addr_i;
  assign wd = busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == LAST_ADDR) begin
        busy_q <= 1'b0;
      end
    end
  end

  // read returns the old contents on a same-address write; the controller forwards
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;
endmodule

// ----- rtl/vas_entry_mem.sv -----
// Neighbor entry memory, one write and one registered read port.
module vas_entry_mem #(
  parameter int AW = 15,
  parameter int DW = 18
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);
  import vas_pkg::*;

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
endmodule

// ----- rtl/vas_ctrl.sv -----
// Sequencer: reads, modifies and writes back node records and neighbor entries.
module vas_ctrl #(
  parameter int NODE_COUNT   = vas_pkg::NODE_COUNT_DEF,
  parameter int DEGREE_LIMIT = vas_pkg::DEGREE_LIMIT_DEF,
  parameter int VERSION_BITS = vas_pkg::VERSION_BITS_DEF,
  parameter int ID_BITS      = vas_pkg::ID_BITS_DEF,
  parameter int AW           = $clog2(NODE_COUNT),
  parameter int RW           = 2 + VERSION_BITS + $clog2(DEGREE_LIMIT + 1),
  parameter int EAW          = AW + ((DEGREE_LIMIT > 1) ? $clog2(DEGREE_LIMIT) : 1),
  parameter int EW           = ID_BITS + VERSION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           busy_i,
  input  logic [vas_pkg::MAXDEG_W-1:0]   max_degree_i,
  input  logic                           delete_enabled_i,
  vas_in_if.sink                         in_i,
  vas_out_if.source                      out_o,
  output logic                           nrd_en_o,
  output logic [AW-1:0]                  nrd_addr_o,
  input  logic [RW-1:0]                  nrd_data_i,
  output logic                           nwr_en_o,
  output logic [AW-1:0]                  nwr_addr_o,
  output logic [RW-1:0]                  nwr_data_o,
  output logic                           erd_en_o,
  output logic [EAW-1:0]                 erd_addr_o,
  input  logic [EW-1:0]                  erd_data_i,
  output logic                           ewr_en_o,
  output logic [EAW-1:0]                 ewr_addr_o,
  output logic [EW-1:0]                  ewr_data_o
);
  import vas_pkg::*;

  localparam int VB = VERSION_BITS;
  localparam int IW = EAW - AW;
  localparam int DW = RW - 2 - VB;
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int XW = AW + ID_BITS;
  localparam logic [VB-1:0] VMAX = {VB{1'b1}};
  localparam logic [LEN_W-1:0] DL = LEN_W'(DEGREE_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE, S_NODE, S_NBR, S_ENT, S_VER, S_FIN
  } state_e;

  function automatic logic [AW-1:0] to_addr(input logic [ID_BITS-1:0] id);
    logic [XW-1:0] x;
    x = XW'(id);
    return x[AW-1:0];
  endfunction

  function automatic logic in_rng(input logic [ID_BITS-1:0] id);
    return XW'(id) < XW'(NODE_COUNT);
  endfunction

  function automatic logic [TOTAL_W-1:0] to_total(input logic [CW-1:0] v);
    logic [CW+TOTAL_W-1:0] x;
    x = (CW + TOTAL_W)'(v);
    return x[TOTAL_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] to_cnt(input logic [DW-1:0] v);
    logic [DW+CNT_W-1:0] x;
    x = (DW + CNT_W)'(v);
    return x[CNT_W-1:0];
  endfunction

  state_e               state_q, state_d;
  kind_e                kind_q, kind_d;
  logic [ID_BITS-1:0]   node_q, node_d, nbr_q, nbr_d;
  logic [LEN_W-1:0]     len_q, len_d, idx_q, idx_d;
  status_e              fst_q, fst_d;
  logic [DW-1:0]        fcnt_q, fcnt_d, deg_q, deg_d, i_q, i_d;
  logic [RW-1:0]        wrec_q, wrec_d;
  logic                 pend_q, pend_d;
  logic [ID_BITS-1:0]   pend_id_q, pend_id_d;
  logic [CW-1:0]        pc_q, pc_d, hi_q, hi_d;

  logic                 ov_q, ov_d;
  status_e              os_q, os_d;
  logic [ID_BITS-1:0]   oid_q, oid_d;
  logic                 onv_q, onv_d, olast_q, olast_d;
  logic [CNT_W-1:0]     ocnt_q, ocnt_d;
  logic [TOTAL_W-1:0]   onc_q, onc_d, olim_q, olim_d;

  logic                 out_free;
  logic [LEN_W-1:0]     lim;
  logic [RW-1:0]        rec, nrec;
  logic                 r_present, r_known;
  logic [VB-1:0]        r_ver;
  logic [DW-1:0]        r_deg;
  logic [ID_BITS-1:0]   e_id;
  logic [VB-1:0]        e_ver, cur_ver;
  logic                 surv;
  logic [DW-1:0]        i_nx;
  logic [CW-1:0]        node_p1;

  assign out_free = !ov_q || out_o.ready;
  assign lim = (LEN_W'(max_degree_i) > DL) ? DL : LEN_W'(max_degree_i);
  assign in_i.ready = (state_q == S_IDLE) && !busy_i;

  assign rec       = nrd_data_i;
  assign r_present = rec[RW-1] && in_rng(node_q);
  assign r_known   = rec[RW-2] && in_rng(node_q);
  assign r_ver     = rec[DW+VB-1:DW];
  assign r_deg     = rec[DW-1:0];
  assign e_id      = erd_data_i[ID_BITS-1:0];
  assign e_ver     = erd_data_i[EW-1:ID_BITS];
  // ids beyond the node range compare against version zero
  assign cur_ver   = in_rng(e_id) ? rec[DW+VB-1:DW] : '0;
  assign surv      = !delete_enabled_i || (cur_ver == e_ver);
  assign i_nx      = i_q + 1'b1;
  assign node_p1   = CW'(to_addr(node_q)) + 1'b1;

  always_comb begin
    state_d = state_q;  kind_d = kind_q;  node_d = node_q;  nbr_d = nbr_q;
    len_d = len_q;  idx_d = idx_q;  fst_d = fst_q;  fcnt_d = fcnt_q;
    deg_d = deg_q;  i_d = i_q;  wrec_d = wrec_q;  pend_d = pend_q;
    pend_id_d = pend_id_q;  pc_d = pc_q;  hi_d = hi_q;
    ov_d = ov_q && !out_o.ready;
    os_d = os_q;  oid_d = oid_q;  onv_d = onv_q;  olast_d = olast_q;
    ocnt_d = ocnt_q;  onc_d = onc_q;  olim_d = olim_q;
    nrd_en_o = 1'b0;  nrd_addr_o = to_addr(node_q);
    nwr_en_o = 1'b0;  nwr_addr_o = to_addr(node_q);  nwr_data_o = rec;
    erd_en_o = 1'b0;  erd_addr_o = {to_addr(node_q), i_q[IW-1:0]};
    ewr_en_o = 1'b0;  ewr_addr_o = {to_addr(node_q), idx_q[IW-1:0]};
    ewr_data_o = {{VB{1'b0}}, nbr_q};
    nrec = rec;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && !busy_i) begin
          kind_d = kind_e'(in_i.kind);
          node_d = in_i.node_id;
          nbr_d  = in_i.nbr_id;
          len_d  = in_i.list_length;
          idx_d  = in_i.element_index;
          fst_d  = ST_OK;
          fcnt_d = '0;
          pend_d = 1'b0;
          state_d = S_FIN;
          nrd_addr_o = to_addr(in_i.node_id);
          unique case (kind_e'(in_i.kind))
            KIND_INSERT: begin
              if (in_i.list_length > lim) begin
                fst_d = ST_TOO_LONG;
              end else if (in_rng(in_i.node_id) && !(in_i.list_length != '0 &&
                           in_i.element_index >= in_i.list_length)) begin
                nrd_en_o = 1'b1;
                state_d  = S_NODE;
              end
            end
            KIND_READ, KIND_SIZE: begin
              if (in_rng(in_i.node_id)) begin
                nrd_en_o = 1'b1;
                state_d  = S_NODE;
              end
            end
            KIND_DELETE: begin
              if (!delete_enabled_i) begin
                fst_d = ST_DISABLED;
              end else if (in_rng(in_i.node_id)) begin
                nrd_en_o = 1'b1;
                state_d  = S_NODE;
              end
            end
            KIND_RECOVER: begin
              if (!delete_enabled_i) begin
                fst_d = ST_DISABLED;
              end else if (!in_rng(in_i.node_id)) begin
                fst_d = ST_UNKNOWN;
              end else begin
                nrd_en_o = 1'b1;
                state_d  = S_NODE;
              end
            end
            default: ;
          endcase
        end
      end
      S_NODE: begin
        state_d = S_FIN;
        unique case (kind_q)
          KIND_INSERT: begin
            nrec = rec;
            nrec[RW-1] = 1'b1;
            if (!rec[RW-1]) begin
              pc_d = pc_q + 1'b1;
              if (delete_enabled_i) begin
                nrec[RW-2] = 1'b1;
                nrec[DW+VB-1:DW] = '0;
              end
            end
            nrec[DW-1:0] = DW'(len_q);
            nwr_en_o   = 1'b1;
            nwr_data_o = nrec;
            wrec_d     = nrec;
            if (node_p1 > hi_q) begin
              hi_d = node_p1;
            end
            if (len_q != '0) begin
              if (delete_enabled_i && in_rng(nbr_q)) begin
                nrd_en_o   = 1'b1;
                nrd_addr_o = to_addr(nbr_q);
                state_d    = S_NBR;
              end else begin
                ewr_en_o = 1'b1;
              end
            end
          end
          KIND_READ: begin
            if (r_present && r_deg != '0) begin
              deg_d    = r_deg;
              i_d      = '0;
              erd_en_o = 1'b1;
              erd_addr_o = {to_addr(node_q), {IW{1'b0}}};
              state_d  = S_ENT;
            end
          end
          KIND_SIZE: begin
            fcnt_d = r_present ? r_deg : '0;
          end
          KIND_DELETE: begin
            if (r_known) begin
              if (r_ver == VMAX) begin
                fst_d = ST_OVERFLOW;
              end else begin
                nrec[DW+VB-1:DW] = r_ver + 1'b1;
                nwr_en_o   = 1'b1;
                nwr_data_o = nrec;
              end
            end
          end
          KIND_RECOVER: begin
            if (!r_known) begin
              fst_d = ST_UNKNOWN;
            end else if (r_ver == '0) begin
              fst_d = ST_UNDERFLOW;
            end else begin
              nrec[DW+VB-1:DW] = r_ver - 1'b1;
              nwr_en_o   = 1'b1;
              nwr_data_o = nrec;
            end
          end
          default: ;
        endcase
      end
      S_NBR: begin
        // forward the record just written when the neighbor is the node itself
        nrec = (nbr_q == node_q) ? wrec_q : rec;
        nrec[RW-2] = 1'b1;
        nwr_en_o   = 1'b1;
        nwr_addr_o = to_addr(nbr_q);
        nwr_data_o = nrec;
        ewr_en_o   = 1'b1;
        ewr_data_o = {nrec[DW+VB-1:DW], nbr_q};
        state_d    = S_FIN;
      end
      S_ENT: begin
        nrd_en_o   = in_rng(e_id);
        nrd_addr_o = to_addr(e_id);
        state_d    = S_VER;
      end
      S_VER: begin
        if (!(surv && pend_q && !out_free)) begin
          if (surv) begin
            if (pend_q) begin
              ov_d = 1'b1;  os_d = ST_OK;  oid_d = pend_id_q;  onv_d = 1'b1;
              olast_d = 1'b0;  ocnt_d = '0;  onc_d = '0;  olim_d = '0;
            end
            pend_d    = 1'b1;
            pend_id_d = e_id;
          end
          i_d = i_nx;
          if (i_nx < deg_q) begin
            erd_en_o   = 1'b1;
            erd_addr_o = {to_addr(node_q), i_nx[IW-1:0]};
            state_d    = S_ENT;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_d = 1'b1;  os_d = fst_q;  oid_d = '0;  onv_d = 1'b0;  olast_d = 1'b1;
          ocnt_d = '0;  onc_d = '0;  olim_d = '0;
          if (kind_q == KIND_READ && pend_q) begin
            oid_d = pend_id_q;
            onv_d = 1'b1;
          end
          if (kind_q == KIND_SIZE) begin
            ocnt_d = to_cnt(fcnt_q);
            onc_d  = to_total(pc_q);
            olim_d = to_total(hi_q);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  kind_q <= KIND_INSERT;  node_q <= '0;  nbr_q <= '0;
      len_q <= '0;  idx_q <= '0;  fst_q <= ST_OK;  fcnt_q <= '0;  deg_q <= '0;
      i_q <= '0;  wrec_q <= '0;  pend_q <= 1'b0;  pend_id_q <= '0;
      pc_q <= '0;  hi_q <= '0;  ov_q <= 1'b0;  os_q <= ST_OK;  oid_q <= '0;
      onv_q <= 1'b0;  olast_q <= 1'b0;  ocnt_q <= '0;  onc_q <= '0;  olim_q <= '0;
    end else begin
      state_q <= state_d;  kind_q <= kind_d;  node_q <= node_d;  nbr_q <= nbr_d;
      len_q <= len_d;  idx_q <= idx_d;  fst_q <= fst_d;  fcnt_q <= fcnt_d;
      deg_q <= deg_d;  i_q <= i_d;  wrec_q <= wrec_d;  pend_q <= pend_d;
      pend_id_q <= pend_id_d;  pc_q <= pc_d;  hi_q <= hi_d;  ov_q <= ov_d;
      os_q <= os_d;  oid_q <= oid_d;  onv_q <= onv_d;  olast_q <= olast_d;
      ocnt_q <= ocnt_d;  onc_q <= onc_d;  olim_q <= olim_d;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.status          = os_q;
  assign out_o.nbr_out         = oid_q;
  assign out_o.neighbor_valid  = onv_q;
  assign out_o.last            = olast_q;
  assign out_o.neighbor_count  = ocnt_q;
  assign out_o.node_count      = onc_q;
  assign out_o.id_limit        = olim_q;
endmodule
